### src/ie_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the infix expression evaluator.
// No dependencies; used by the controller, the datapath and the top level.
package ie_pkg;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVALID  = 3'd1;
   localparam logic [2:0] ST_DIV_ZERO = 3'd2;
   localparam logic [2:0] ST_NO_EQUAL = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   localparam logic [1:0] PH_LEFT  = 2'd0;
   localparam logic [1:0] PH_OPER  = 2'd1;
   localparam logic [1:0] PH_RIGHT = 2'd2;

   typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_type;

   typedef enum logic [1:0] {PEND_ZERO, PEND_TOP, PEND_RES, PEND_ONES} pend_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_OPER, S_OPCHK, S_POPR, S_POPL, S_EXEC, S_BUSY,
      S_PUSHRES, S_PUSHOP, S_FINISH, S_EMIT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       acc_digit;
      logic       push_acc;
      logic       pop_op;
      logic       pop_r;
      logic       pop_l;
      logic       load_res_as;
      logic       mdu_start;
      logic       load_res_mdu;
      logic       push_res;
      logic       push_op;
      logic       set_pend;
      pend_type   pend_kind;
      logic [2:0] pend_status;
      logic       clear;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic   blank;
      logic   digit;
      logic   is_op;
      logic   is_eq;
      logic   op_high;
      logic   phase_oper;
      logic   vfull;
      logic   ofull;
      logic   ocnt_zero;
      logic   top_low;
      logic   text_end;
      op_type cur_op;
      logic   r_zero;
      logic   mdu_done;
      logic   out_free;
      logic   pend;
   } stat_type;

endpackage

### src/ie_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ie_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### src/ie_mdu.sv
`timescale 1ns / 1ps
// Iterative multiply / divide unit: shift-add multiply, restoring divide,
// one bit per cycle. Division truncates toward zero. Depends on nothing.
module ie_mdu #(
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          is_div,
   input  logic [VW-1:0] a,
   input  logic [VW-1:0] b,
   output logic          done,
   output logic [VW-1:0] result
);
   localparam int NW = $clog2(VW);

   logic          busy_ff, done_ff, div_ff, neg_ff;
   logic [NW-1:0] cnt_ff;
   logic [VW-1:0] x_ff, y_ff, p_ff;
   logic [VW-1:0] a_mag, b_mag, rem_in;
   logic [VW:0]   rem_shift, rem_diff;
   logic          rem_ge;

   assign a_mag     = a[VW-1] ? (~a + VW'(1)) : a;
   assign b_mag     = b[VW-1] ? (~b + VW'(1)) : b;
   assign rem_shift = {p_ff, x_ff[VW-1]};
   assign rem_diff  = rem_shift - {1'b0, y_ff};
   assign rem_ge    = rem_shift >= {1'b0, y_ff};
   assign rem_in    = rem_ge ? rem_diff[VW-1:0] : rem_shift[VW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + NW'(1);
            if (cnt_ff == NW'(VW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= is_div;
         neg_ff <= a[VW-1] ^ b[VW-1];
         x_ff   <= is_div ? a_mag : a;
         y_ff   <= is_div ? b_mag : b;
         p_ff   <= '0;
      end else if (busy_ff) begin
         if (div_ff) begin
            p_ff <= rem_in;
            x_ff <= {x_ff[VW-2:0], rem_ge};
         end else begin
            if (y_ff[0]) begin
               p_ff <= p_ff + x_ff;
            end
            x_ff <= {x_ff[VW-2:0], 1'b0};
            y_ff <= {1'b0, y_ff[VW-1:1]};
         end
      end
   end

   assign done   = done_ff;
   assign result = div_ff ? (neg_ff ? (~x_ff + VW'(1)) : x_ff) : p_ff;
endmodule

### src/ie_dp.sv
`timescale 1ns / 1ps
// Datapath: character decode, number accumulator, value and operator stacks,
// arithmetic and the result register. Depends on ie_pkg, ie_ram, ie_mdu.
module ie_dp #(
   parameter int STACK_DEPTH = 4,
   parameter int VW          = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  ie_pkg::cmd_type  cmd,
   output ie_pkg::stat_type stat,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata
);
   import ie_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [7:0]    char_ff;
   logic          end_ff;
   logic [1:0]    phase_ff;
   logic [VW-1:0] acc_ff, top_ff, res_ff, lop_ff, rop_ff, pend_val_ff;
   logic [CW-1:0] vcnt_ff, ocnt_ff;
   op_type        cur_op_ff;
   logic          pend_ff, rsp_valid_ff;
   logic [2:0]    pend_st_ff, rsp_status_ff;
   logic [31:0]   rsp_value_ff;

   logic          blank, digit, is_op;
   op_type        op_k;
   logic [3:0]    dval;
   logic [VW-1:0] acc_next, vwdata, vrdata, addsub, pend_sel, mdu_result;
   logic [CW-1:0] vraddr_full, oraddr_full;
   logic [1:0]    ordata;
   logic          vempty, mdu_done;

   assign blank = (char_ff == CH_SPACE) || (char_ff >= CH_TAB && char_ff <= CH_CR);
   assign digit = (char_ff >= CH_ZERO) && (char_ff <= CH_NINE);
   assign dval  = 4'(char_ff - CH_ZERO);

   always_comb begin
      is_op = 1'b1;
      op_k  = OP_ADD;
      priority if (char_ff == CH_PLUS)  op_k = OP_ADD;
      else if (char_ff == CH_MINUS) op_k = OP_SUB;
      else if (char_ff == CH_STAR)  op_k = OP_MUL;
      else if (char_ff == CH_SLASH) op_k = OP_DIV;
      else is_op = 1'b0;
   end

   // acc * 10 + digit, wrapping
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + VW'(dval);
   assign vempty   = (vcnt_ff == '0);
   assign vwdata   = cmd.push_acc ? acc_ff : res_ff;
   assign addsub   = (cur_op_ff == OP_ADD) ? (lop_ff + rop_ff) : (lop_ff - rop_ff);
   assign vraddr_full = cmd.pop_r ? (vcnt_ff - CW'(2)) : (vcnt_ff - CW'(1));
   assign oraddr_full = ocnt_ff - CW'(1);

   always_comb begin
      unique case (cmd.pend_kind)
         PEND_ZERO: pend_sel = '0;
         PEND_TOP:  pend_sel = vempty ? '0 : top_ff;
         PEND_RES:  pend_sel = res_ff;
         PEND_ONES: pend_sel = '1;
         default:   pend_sel = '0;
      endcase
   end

   ie_ram #(.WIDTH(VW), .DEPTH(STACK_DEPTH)) u_vstack (
      .clock (clock),
      .we    (cmd.push_acc | cmd.push_res),
      .waddr (vcnt_ff[AW-1:0]),
      .wdata (vwdata),
      .raddr (vraddr_full[AW-1:0]),
      .rdata (vrdata)
   );

   ie_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_ostack (
      .clock (clock),
      .we    (cmd.push_op),
      .waddr (ocnt_ff[AW-1:0]),
      .wdata (op_k),
      .raddr (oraddr_full[AW-1:0]),
      .rdata (ordata)
   );

   ie_mdu #(.VW(VW)) u_mdu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mdu_start),
      .is_div (cur_op_ff == OP_DIV),
      .a      (lop_ff),
      .b      (rop_ff),
      .done   (mdu_done),
      .result (mdu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEFT;
         acc_ff       <= '0;
         vcnt_ff      <= '0;
         ocnt_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            phase_ff <= PH_LEFT;
            acc_ff   <= '0;
            vcnt_ff  <= '0;
            ocnt_ff  <= '0;
         end else begin
            if (cmd.acc_digit) begin
               acc_ff <= acc_next;
            end
            if (cmd.push_acc) begin
               vcnt_ff  <= vcnt_ff + CW'(1);
               phase_ff <= PH_OPER;
            end
            if (cmd.push_op) begin
               ocnt_ff  <= ocnt_ff + CW'(1);
               phase_ff <= PH_RIGHT;
               acc_ff   <= '0;
            end
            if (cmd.pop_op) begin
               ocnt_ff <= ocnt_ff - CW'(1);
            end
            if ((cmd.pop_r || cmd.pop_l) && !vempty) begin
               vcnt_ff <= vcnt_ff - CW'(1);
            end
            if (cmd.push_res) begin
               vcnt_ff <= vcnt_ff + CW'(1);
            end
         end
         if (cmd.set_pend) begin
            pend_ff <= 1'b1;
         end else if (cmd.emit) begin
            pend_ff <= 1'b0;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff <= req_tdata;
         end_ff  <= req_tlast;
      end
      if (cmd.push_acc || cmd.push_res) begin
         top_ff <= vwdata;
      end
      if (cmd.pop_op) begin
         cur_op_ff <= op_type'(ordata);
      end
      if (cmd.pop_r) begin
         rop_ff <= vempty ? '0 : vrdata;
      end
      if (cmd.pop_l) begin
         lop_ff <= vempty ? '0 : vrdata;
      end
      if (cmd.load_res_as) begin
         res_ff <= addsub;
      end else if (cmd.load_res_mdu) begin
         res_ff <= mdu_result;
      end
      if (cmd.set_pend) begin
         pend_val_ff <= pend_sel;
         pend_st_ff  <= cmd.pend_status;
      end
      if (cmd.emit) begin
         rsp_value_ff  <= 32'(signed'(pend_val_ff));
         rsp_status_ff <= pend_st_ff;
      end
   end

   always_comb begin
      stat.blank      = blank;
      stat.digit      = digit;
      stat.is_op      = is_op;
      stat.is_eq      = (char_ff == CH_EQUAL);
      stat.op_high    = op_k[1];
      stat.phase_oper = (phase_ff == PH_OPER);
      stat.vfull      = (vcnt_ff == CW'(STACK_DEPTH));
      stat.ofull      = (ocnt_ff == CW'(STACK_DEPTH));
      stat.ocnt_zero  = (ocnt_ff == '0);
      stat.top_low    = !ordata[1];
      stat.text_end   = end_ff;
      stat.cur_op     = cur_op_ff;
      stat.r_zero     = (rop_ff == '0);
      stat.mdu_done   = mdu_done;
      stat.out_free   = !rsp_valid_ff || rsp_tready;
      stat.pend       = pend_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_status_ff, rsp_value_ff};
endmodule

### src/ie_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences decode, stack reductions and result
// delivery. Depends on ie_pkg.
module ie_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  ie_pkg::stat_type stat,
   output ie_pkg::cmd_type  cmd
);
   import ie_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.blank) begin
               state_in = S_FINISH;
            end else if (!stat.phase_oper) begin
               if (stat.digit) begin
                  cmd.acc_digit = 1'b1;
                  state_in      = S_FINISH;
               end else if (stat.vfull) begin
                  cmd.set_pend    = 1'b1;
                  cmd.pend_kind   = PEND_ZERO;
                  cmd.pend_status = ST_OVERFLOW;
                  cmd.clear       = 1'b1;
                  state_in        = S_EMIT;
               end else begin
                  cmd.push_acc = 1'b1;
                  state_in     = S_OPER;
               end
            end else begin
               state_in = S_OPER;
            end
         end
         S_OPER: begin
            if (stat.is_op) begin
               state_in = stat.ocnt_zero ? S_PUSHOP : S_OPCHK;
            end else if (stat.is_eq) begin
               if (stat.ocnt_zero) begin
                  cmd.set_pend    = 1'b1;
                  cmd.pend_kind   = PEND_TOP;
                  cmd.pend_status = ST_OK;
                  cmd.clear       = 1'b1;
                  state_in        = S_EMIT;
               end else begin
                  state_in = S_OPCHK;
               end
            end else begin
               cmd.set_pend    = 1'b1;
               cmd.pend_kind   = PEND_ZERO;
               cmd.pend_status = ST_INVALID;
               state_in        = S_FINISH;
            end
         end
         S_OPCHK: begin
            // a higher-precedence operator stops at a lower one on the stack
            if (!stat.is_eq && stat.top_low && stat.op_high) begin
               state_in = S_PUSHOP;
            end else begin
               cmd.pop_op = 1'b1;
               state_in   = S_POPR;
            end
         end
         S_POPR: begin
            cmd.pop_r = 1'b1;
            state_in  = S_POPL;
         end
         S_POPL: begin
            cmd.pop_l = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            unique case (stat.cur_op)
               OP_ADD, OP_SUB: begin
                  cmd.load_res_as = 1'b1;
                  state_in        = S_PUSHRES;
               end
               OP_MUL: begin
                  cmd.mdu_start = 1'b1;
                  state_in      = S_BUSY;
               end
               OP_DIV: begin
                  if (stat.r_zero) begin
                     cmd.set_pend    = 1'b1;
                     cmd.pend_kind   = PEND_ZERO;
                     cmd.pend_status = ST_DIV_ZERO;
                     cmd.clear       = 1'b1;
                     state_in        = S_EMIT;
                  end else begin
                     cmd.mdu_start = 1'b1;
                     state_in      = S_BUSY;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_BUSY: begin
            if (stat.mdu_done) begin
               cmd.load_res_mdu = 1'b1;
               state_in         = S_PUSHRES;
            end
         end
         S_PUSHRES: begin
            cmd.push_res = 1'b1;
            if (!stat.ocnt_zero) begin
               state_in = S_OPCHK;
            end else if (stat.is_eq) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_kind   = PEND_RES;
               cmd.pend_status = ST_OK;
               cmd.clear       = 1'b1;
               state_in        = S_EMIT;
            end else begin
               state_in = S_PUSHOP;
            end
         end
         S_PUSHOP: begin
            if (stat.ofull) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_kind   = PEND_ZERO;
               cmd.pend_status = ST_OVERFLOW;
               cmd.clear       = 1'b1;
               state_in        = S_EMIT;
            end else begin
               cmd.push_op = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            // end of text overrides an invalid-character report
            if (stat.text_end) begin
               cmd.set_pend    = 1'b1;
               cmd.pend_kind   = PEND_ONES;
               cmd.pend_status = ST_NO_EQUAL;
               cmd.clear       = 1'b1;
               state_in        = S_EMIT;
            end else if (stat.pend) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

### src/infix_expression_evaluator_top.sv
`timescale 1ns / 1ps
// Infix expression evaluator, top level: controller plus datapath.
// Depends on ie_pkg, ie_ctrl, ie_dp.
//
// Usage:
//   req_*: one ASCII character per transaction; req_tlast marks the last
//   character of the text. rsp_*: at most one result per character,
//   value and status. Results are held in an output register until taken.
//   An operator or '=' may trigger stack reductions; each * or /
//   reduction runs in the bit-serial multiply/divide unit. One
//   character is worked on at a time; req_tready is high
//   while the controller waits for the next character.
//   If rsp_tready is low the finished result stays in the output register;
//   the next character is still taken, and the block waits only when it
//   has a new result and the register is still full.
//   Reset (synchronous, active high) empties both stacks, clears the
//   accumulator and drops any undelivered result.
module infix_expression_evaluator_top #(
   parameter int STACK_DEPTH = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] value, [34:32] status, rest zero
);
   import ie_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ie_dp #(.STACK_DEPTH(STACK_DEPTH), .VW(VALUE_WIDTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
